### design/clrng_pkg.sv
// types, constants and microcode table of the combined lcg shuffle generator
package clrng_pkg;

  localparam logic [15:0] MUL_ONE     = 16'd40014;
  localparam logic [15:0] MUL_TWO     = 16'd40692;
  localparam logic [30:0] MOD_ONE     = 31'd2147483563;
  localparam logic [30:0] MOD_TWO     = 31'd2147483399;
  // 2^31 folded back into each modulus
  localparam logic [7:0]  FOLD_ONE    = 8'd85;
  localparam logic [7:0]  FOLD_TWO    = 8'd249;
  localparam logic [30:0] WRAP_ADD    = 31'd2147483562;
  localparam logic [30:0] FIRST_INIT  = 31'd1;
  localparam logic [30:0] SECOND_INIT = 31'd123456789;
  localparam int          WARM_EXTRA  = 8;

  typedef logic [3:0] pc_t;

  typedef enum logic {
    GEN_FIRST,
    GEN_SECOND
  } gen_t;

  typedef enum logic [2:0] {
    J_NEXT,
    J_GOTO,
    J_ACCEPT,
    J_LOOP,
    J_OUT
  } jump_t;

  typedef struct packed {
    gen_t  gen;
    logic  idx_ld;
    logic  rd_en;
    logic  wb_first;
    logic  wb_second;
    logic  tbl_wr;
    logic  warm;
    logic  so_first;
    logic  out_ld;
    jump_t jmp;
    pc_t   target;
  } ucw_t;

  typedef struct packed {
    gen_t gen;
    logic idx_ld;
    logic rd_en;
    logic wb_first;
    logic wb_second;
    logic tbl_wr;
    logic warm;
    logic so_first;
    logic out_ld;
    logic accept;
  } ctrl_t;

  localparam pc_t PC_IDLE = 4'd0;
  localparam pc_t PC_D1   = 4'd1;
  localparam pc_t PC_D2   = 4'd2;
  localparam pc_t PC_D3   = 4'd3;
  localparam pc_t PC_D4   = 4'd4;
  localparam pc_t PC_R0   = 4'd5;
  localparam pc_t PC_R1   = 4'd6;
  localparam pc_t PC_R2   = 4'd7;
  localparam pc_t PC_R3   = 4'd8;
  localparam pc_t PC_D0   = 4'd9;

  function automatic ucw_t ucode(pc_t pc);
    ucw_t w;
    w = '0;
    case (pc)
      PC_IDLE: begin
        w.gen = GEN_FIRST; w.idx_ld = 1'b1; w.jmp = J_ACCEPT; w.target = PC_R0;
      end
      PC_D1: begin
        w.gen = GEN_SECOND; w.rd_en = 1'b1; w.jmp = J_NEXT;
      end
      PC_D2: begin
        w.wb_first = 1'b1; w.tbl_wr = 1'b1; w.jmp = J_NEXT;
      end
      PC_D3: begin
        w.wb_second = 1'b1; w.jmp = J_NEXT;
      end
      PC_D4: begin
        w.out_ld = 1'b1; w.jmp = J_OUT; w.target = PC_IDLE;
      end
      PC_R0: begin
        w.gen = GEN_FIRST; w.jmp = J_NEXT;
      end
      PC_R1: begin
        w.jmp = J_NEXT;
      end
      PC_R2: begin
        w.wb_first = 1'b1; w.warm = 1'b1; w.jmp = J_LOOP; w.target = PC_R0;
      end
      PC_R3: begin
        w.so_first = 1'b1; w.jmp = J_NEXT;
      end
      PC_D0: begin
        w.gen = GEN_FIRST; w.idx_ld = 1'b1; w.jmp = J_GOTO; w.target = PC_D1;
      end
      default: begin
        w.jmp = J_GOTO; w.target = PC_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

### design/clrng_ram.sv
// generic single-write, single-read ram with registered read data
module clrng_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/clrng_mulmod.sv
// pipelined multiply, fold and conditional subtract, shared by both generators
module clrng_mulmod (
  input  logic              clk,
  input  clrng_pkg::gen_t   gen,
  input  logic [30:0]       x,
  output logic [30:0]       red
);
  import clrng_pkg::*;

  logic [46:0] prod;
  gen_t        sel1;
  logic [31:0] fold;
  gen_t        sel2;
  logic [15:0] mul_a;
  logic [7:0]  fold_k;
  logic [23:0] hik;
  logic [31:0] fold_next;
  logic [31:0] modw;
  logic [31:0] diff;

  always_comb begin
    mul_a     = (gen == GEN_FIRST) ? MUL_ONE : MUL_TWO;
    fold_k    = (sel1 == GEN_FIRST) ? FOLD_ONE : FOLD_TWO;
    hik       = prod[46:31] * fold_k;
    fold_next = {8'b0, hik} + {1'b0, prod[30:0]};
    modw      = {1'b0, (sel2 == GEN_FIRST) ? MOD_ONE : MOD_TWO};
    diff      = fold - modw;
    red       = (fold >= modw) ? diff[30:0] : fold[30:0];
  end

  always_ff @(posedge clk) begin
    prod <= x * mul_a;
    sel1 <= gen;
    fold <= fold_next;
    sel2 <= sel1;
  end

endmodule

### design/clrng_seq.sv
// microcode sequencer: step counter, control rom and jump logic
module clrng_seq (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             operation,
  input  logic             warm_last,
  input  logic             out_free,
  output logic             item_ready,
  output clrng_pkg::ctrl_t ctrl
);
  import clrng_pkg::*;

  pc_t  pc;
  pc_t  pc_next;
  ucw_t w;
  logic accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  always_comb begin
    w          = ucode(pc);
    item_ready = (w.jmp == J_ACCEPT);
    accept     = item_ready && item_valid;

    ctrl.gen       = w.gen;
    ctrl.idx_ld    = w.idx_ld;
    ctrl.rd_en     = w.rd_en;
    ctrl.wb_first  = w.wb_first;
    ctrl.wb_second = w.wb_second;
    ctrl.tbl_wr    = w.tbl_wr;
    ctrl.warm      = w.warm;
    ctrl.so_first  = w.so_first;
    ctrl.out_ld    = w.out_ld && out_free;
    ctrl.accept    = accept;

    case (w.jmp)
      J_NEXT:   pc_next = pc_t'(pc + 4'd1);
      J_GOTO:   pc_next = w.target;
      J_ACCEPT: begin
        if (!accept) begin
          pc_next = pc;
        end else if (operation) begin
          pc_next = w.target;
        end else begin
          pc_next = pc_t'(pc + 4'd1);
        end
      end
      J_LOOP:   pc_next = warm_last ? pc_t'(pc + 4'd1) : w.target;
      J_OUT:    pc_next = out_free ? w.target : pc;
      default:  pc_next = PC_IDLE;
    endcase
  end

endmodule

### design/combined_lcg_shuffle_rng_top.sv
// top level of the combined lcg generator with shuffle table
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+-------------------------------
//   item     | item_valid / item_ready     | operation (1), seed (31)
//   result   | result_valid / result_ready | value (31)
//
// a draw steps both generators through the multiply-reduce unit, and a new item
// is taken only once the sequencer is back in idle; a reseed first runs a warm-up
// that refills the table. the two generators share the pipelined unit, one step
// at a time. after reset the table reads as zero through per-entry valid bits.
// a result that is not taken holds the last step until result_ready.
module combined_lcg_shuffle_rng_top #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic        operation,
  input  logic [30:0] seed,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [30:0] value
);
  import clrng_pkg::*;

  localparam int          AW      = $clog2(TABLE_DEPTH);
  localparam int          CW      = $clog2(TABLE_DEPTH + WARM_EXTRA);
  localparam logic [31:0] IDX_DIV = 32'(1 + 2147483562 / TABLE_DEPTH);

  ctrl_t             ctrl;
  logic [30:0]       first_lcg;
  logic [30:0]       second_lcg;
  logic [30:0]       shuffle_out;
  logic [AW-1:0]     idx;
  logic [AW-1:0]     idx_next;
  logic [CW-1:0]     cnt;
  logic [TABLE_DEPTH-1:0] vld;
  logic              ent_vld;
  logic [30:0]       rdata;
  logic [30:0]       entry;
  logic [30:0]       red;
  logic [30:0]       mul_x;
  logic [30:0]       seed_eff;
  logic              warm_last;
  logic              warm_wr;
  logic              tbl_we;
  logic [AW-1:0]     tbl_waddr;
  logic              out_free;
  logic [32:0]       diff;
  logic [32:0]       wrapped;
  logic [30:0]       result;

  clrng_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .operation  (operation),
    .warm_last  (warm_last),
    .out_free   (out_free),
    .item_ready (item_ready),
    .ctrl       (ctrl)
  );

  clrng_mulmod u_mulmod (
    .clk (clk),
    .gen (ctrl.gen),
    .x   (mul_x),
    .red (red)
  );

  clrng_ram #(
    .WIDTH (31),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (red),
    .re    (ctrl.rd_en),
    .raddr (idx),
    .rdata (rdata)
  );

  always_comb begin
    mul_x     = (ctrl.gen == GEN_FIRST) ? first_lcg : second_lcg;
    seed_eff  = (seed == 31'd0) ? 31'd1 : seed;
    warm_last = (cnt == '0);
    warm_wr   = ctrl.warm && (cnt < CW'(TABLE_DEPTH));
    tbl_we    = ctrl.tbl_wr || warm_wr;
    tbl_waddr = ctrl.warm ? cnt[AW-1:0] : idx;
    out_free  = !result_valid || result_ready;

    idx_next = '0;
    for (int k = 1; k < TABLE_DEPTH; k++) begin
      if ({1'b0, shuffle_out} >= 32'(k) * IDX_DIV) begin
        idx_next = AW'(k);
      end
    end

    entry   = ent_vld ? rdata : 31'd0;
    diff    = {2'b0, entry} - {2'b0, second_lcg};
    wrapped = (diff[32] || diff == '0) ? diff + {2'b0, WRAP_ADD} : diff;
    result  = wrapped[30:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_lcg    <= FIRST_INIT;
      second_lcg   <= SECOND_INIT;
      shuffle_out  <= '0;
      vld          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (ctrl.accept && operation) begin
        first_lcg  <= seed_eff;
        second_lcg <= seed_eff;
      end else begin
        if (ctrl.wb_first) begin
          first_lcg <= red;
        end
        if (ctrl.wb_second) begin
          second_lcg <= red;
        end
      end
      if (ctrl.so_first) begin
        shuffle_out <= first_lcg;
      end else if (ctrl.out_ld) begin
        shuffle_out <= result;
      end
      if (tbl_we) begin
        vld[tbl_waddr] <= 1'b1;
      end
      if (ctrl.out_ld) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.idx_ld) begin
      idx <= idx_next;
    end
    if (ctrl.rd_en) begin
      ent_vld <= vld[idx];
    end
    if (ctrl.accept && operation) begin
      cnt <= CW'(TABLE_DEPTH + WARM_EXTRA - 1);
    end else if (ctrl.warm && !warm_last) begin
      cnt <= cnt - CW'(1);
    end
    if (ctrl.out_ld) begin
      value <= result;
    end
  end

endmodule

### design/clrng_chk.sv
// port-level checker for the combined lcg generator, bound to the top level
module clrng_chk (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_ready,
  input logic        operation,
  input logic        result_valid,
  input logic        result_ready,
  input logic [30:0] value
);
  import clrng_pkg::*;

  // held result keeps its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(value))
    else $error("held result changed");

  a_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> value != 31'd0 && value <= WRAP_ADD)
    else $error("result out of range");

  // one transaction at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("accepted while busy");

  a_draw_lat: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && !operation && !result_valid |-> ##5 result_valid)
    else $error("draw latency wrong");

  a_back_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> item_ready)
    else $error("not idle after result");

endmodule

bind combined_lcg_shuffle_rng_top clrng_chk u_chk (.*);

### dv/combined_lcg_shuffle_rng_top_tb.sv
// testbench for the combined lcg shuffle generator: draws and reseeds checked against a predictor
`timescale 1ns / 1ps

module combined_lcg_shuffle_rng_top_tb;

  localparam int          TABLE_DEPTH = 32;
  localparam logic [63:0] MULT_A      = 64'd40014;
  localparam logic [63:0] MULT_B      = 64'd40692;
  localparam logic [63:0] MODULUS_A   = 64'd2147483563;
  localparam logic [63:0] MODULUS_B   = 64'd2147483399;
  localparam longint      WRAP_VALUE  = 64'd2147483562;
  localparam logic [30:0] SLOT_DIV    = 31'(1 + 2147483562 / TABLE_DEPTH);
  localparam logic        OP_DRAW     = 1'b0;
  localparam logic        OP_RESEED   = 1'b1;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam int          DRAIN_WAIT  = 200;

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_ready;
  logic        operation;
  logic [30:0] seed;
  logic        result_valid;
  logic        result_ready;
  logic [30:0] value;

  // predictor state
  logic [30:0] gen_a;
  logic [30:0] gen_b;
  logic [30:0] shuffle_reg;
  logic [30:0] shuffle_tbl [TABLE_DEPTH];

  logic [30:0] pending_values [$];
  logic [30:0] expected_now;
  int          errors;
  int          cycle_count;
  bit          idle_on;
  int          hold_len;
  bit          holding;

  combined_lcg_shuffle_rng_top #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .operation(operation),
    .seed(seed),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .value(value)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic logic [30:0] step_gen_a(logic [30:0] x);
    return 31'((MULT_A * 64'(x)) % MODULUS_A);
  endfunction

  function automatic logic [30:0] step_gen_b(logic [30:0] x);
    return 31'((MULT_B * 64'(x)) % MODULUS_B);
  endfunction

  function automatic void model_reseed(logic [30:0] s);
    logic [30:0] start;
    start = (s == 31'd0) ? 31'd1 : s;
    gen_a = start;
    gen_b = start;
    for (int n = TABLE_DEPTH + 7; n >= 0; n--) begin
      gen_a = step_gen_a(gen_a);
      if (n < TABLE_DEPTH) shuffle_tbl[n] = gen_a;
    end
    shuffle_reg = shuffle_tbl[0];
  endfunction

  function automatic logic [30:0] model_draw();
    logic [30:0] slot;
    longint      diff;
    gen_a = step_gen_a(gen_a);
    gen_b = step_gen_b(gen_b);
    slot = shuffle_reg / SLOT_DIV;
    if (slot >= TABLE_DEPTH) slot = 31'(TABLE_DEPTH - 1);
    diff = longint'(shuffle_tbl[slot]);
    diff = diff - longint'(gen_b);
    shuffle_tbl[slot] = gen_a;
    if (diff < 1) diff = diff + WRAP_VALUE;
    shuffle_reg = 31'(diff);
    return shuffle_reg;
  endfunction

  // offer one transaction, predict its value once accepted
  task automatic send_request(input logic op, input logic [30:0] s);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    item_valid <= 1'b1;
    operation  <= op;
    seed       <= s;
    do @(posedge clk); while (!item_ready);
    if (op == OP_RESEED) model_reseed(s);
    pending_values.push_back(model_draw());
  endtask

  task automatic stop_sending();
    item_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_draw_from_reset();
    repeat (4) send_request(OP_DRAW, 31'(SLOT_DIV));
    stop_sending();
  endtask

  task automatic test_seed_extremes();
    send_request(OP_RESEED, 31'd0);
    send_request(OP_RESEED, 31'd1);
    send_request(OP_RESEED, 31'h7FFFFFFF);
    send_request(OP_RESEED, 31'd2147483562);
    send_request(OP_RESEED, 31'd2147483564);
    send_request(OP_RESEED, 31'd2147483399);
    send_request(OP_RESEED, 31'd2147483398);
    send_request(OP_RESEED, 31'h55555555);
    send_request(OP_RESEED, 31'h2AAAAAAA);
    // seed equal to the first modulus collapses the first generator to zero
    send_request(OP_RESEED, 31'd2147483563);
    send_request(OP_DRAW, 31'd0);
    send_request(OP_DRAW, 31'h7FFFFFFF);
    // seed field ignored on a draw
    send_request(OP_RESEED, 31'd42);
    send_request(OP_DRAW, 31'h7FFFFFFF);
    stop_sending();
  endtask

  task automatic test_random_traffic(input int count);
    logic [30:0] s;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0: s = 31'd0;
        1: s = 31'(2147483563 + $urandom_range(0, 84) - 2);
        2: s = 31'(2147483399 + $urandom_range(0, 248) - 2);
        default: s = 31'($urandom);
      endcase
      send_request(($urandom_range(0, 99) < 15) ? OP_RESEED : OP_DRAW, s);
    end
    stop_sending();
  endtask

  task automatic test_output_stall();
    hold_len = 400;
    wait (holding);
    for (int i = 0; i < 24; i++)
      send_request(($urandom_range(0, 5) == 0) ? OP_RESEED : OP_DRAW, 31'($urandom));
    stop_sending();
    wait (!holding);
  endtask

  task automatic test_full_rate(input int count);
    idle_on = 1'b0;
    for (int i = 0; i < count; i++)
      send_request(($urandom_range(0, 19) == 0) ? OP_RESEED : OP_DRAW, 31'($urandom));
    stop_sending();
  endtask

  // result side: random stall bursts, a forced long hold on request
  initial begin
    result_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_len > 0) begin
        holding = 1'b1;
        result_ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
        holding  = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        result_ready <= 1'b1;
        repeat (idle_on ? $urandom_range(1, 40) : 1) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (pending_values.size() == 0) begin
        $display("%0t value expected none got %0d", $time, value);
        errors++;
      end else begin
        expected_now = pending_values.pop_front();
        if (value !== expected_now) begin
          $display("%0t value expected %0d got %0d", $time, expected_now, value);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) cycle_count++;

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("combined_lcg_shuffle_rng_top: mismatch");
    $finish;
  end

  initial begin
    rst         = 1'b1;
    item_valid  = 1'b0;
    operation   = OP_DRAW;
    seed        = 31'd0;
    errors      = 0;
    cycle_count = 0;
    idle_on     = 1'b1;
    hold_len    = 0;
    holding     = 1'b0;
    gen_a       = 31'd1;
    gen_b       = 31'd123456789;
    shuffle_reg = 31'd0;
    for (int n = 0; n < TABLE_DEPTH; n++) shuffle_tbl[n] = 31'd0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_draw_from_reset();
    test_seed_extremes();
    test_random_traffic(1400);
    test_output_stall();
    test_full_rate(100);

    wait (pending_values.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("combined_lcg_shuffle_rng_top: match");
    end else begin
      $display("combined_lcg_shuffle_rng_top: mismatch");
    end
    $finish;
  end

endmodule

### filelist.f
design/clrng_pkg.sv
design/clrng_ram.sv
design/clrng_mulmod.sv
design/clrng_seq.sv
design/combined_lcg_shuffle_rng_top.sv
design/clrng_chk.sv
dv/combined_lcg_shuffle_rng_top_tb.sv
